FILE: sv/rndc_pkg.sv
package rndc_pkg;

  // Widths fixed by the interface
  localparam int VALUE_BITS = 32;
  localparam int MAX_DIGITS = 32;
  localparam int RADIX_W    = 6;
  localparam int MINL_W     = 6;
  localparam int CFG_W      = 64;
  localparam int CFG_IDX_W  = 3;
  localparam int CHAR_W     = 8;
  localparam int DIGIT_W    = 5;
  localparam int TABLE_N    = 32;
  localparam int TABLE_W    = TABLE_N * CHAR_W;

  // Derived widths
  localparam int CNT_W     = $clog2(MAX_DIGITS + 1);
  localparam int IDX_W     = $clog2(MAX_DIGITS);
  localparam int DIV_CNT_W = $clog2(VALUE_BITS);

  // Radix limits
  localparam logic [RADIX_W-1:0] RADIX_MIN = RADIX_W'(2);
  localparam logic [RADIX_W-1:0] RADIX_MAX = RADIX_W'(32);

  // Reset values of the configuration registers
  localparam logic [RADIX_W-1:0] RADIX_RST      = RADIX_W'(10);
  localparam logic [MINL_W-1:0]  MIN_LENGTH_RST = '0;
  localparam logic [CFG_W-1:0]   CHARS_LOW_RST  = 64'h3736353433323130;
  localparam logic [CFG_W-1:0]   CHARS_MID_RST  = 64'h6665646362613938;
  localparam logic [CFG_W-1:0]   CHARS_HIGH_RST = '0;
  localparam logic [CFG_W-1:0]   CHARS_TOP_RST  = '0;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RADIX      = 3'd0,
    REG_MIN_LENGTH = 3'd1,
    REG_CHARS_LOW  = 3'd2,
    REG_CHARS_MID  = 3'd3,
    REG_CHARS_HIGH = 3'd4,
    REG_CHARS_TOP  = 3'd5
  } cfg_reg_t;

  // Controller to datapath
  typedef struct packed {
    logic load;        // take a new number
    logic div_start;   // start one division by the base
    logic store;       // keep the remainder as the next digit
    logic emit_setup;  // set up pad and digit counters
    logic emit_step;   // load the next character into the output register
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic div_done;    // quotient and remainder ready
    logic more;        // another digit follows
    logic out_free;    // output register can take a character
    logic emit_last;   // next character is the final one
  } status_t;

endpackage

FILE: sv/rndc_div.sv
module rndc_div (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic [rndc_pkg::VALUE_BITS-1:0]   dividend,
  input  logic [rndc_pkg::RADIX_W-1:0]      divisor,
  output logic [rndc_pkg::VALUE_BITS-1:0]   quotient,
  output logic [rndc_pkg::DIGIT_W-1:0]      remainder,
  output logic                              done
);

  logic [rndc_pkg::VALUE_BITS-1:0] q;
  logic [rndc_pkg::RADIX_W-1:0]    r;
  logic [rndc_pkg::DIV_CNT_W-1:0]  cnt;
  logic                            busy;

  logic [rndc_pkg::RADIX_W:0]   trial;
  logic [rndc_pkg::RADIX_W:0]   diff;
  logic                         ge;
  logic [rndc_pkg::RADIX_W-1:0] r_next;
  logic                         last;

  // Restoring division, one quotient bit a cycle
  assign trial  = {r, q[rndc_pkg::VALUE_BITS-1]};
  assign ge     = trial >= {1'b0, divisor};
  assign diff   = trial - {1'b0, divisor};
  assign r_next = ge ? diff[rndc_pkg::RADIX_W-1:0] : trial[rndc_pkg::RADIX_W-1:0];
  assign last   = cnt == rndc_pkg::DIV_CNT_W'(rndc_pkg::VALUE_BITS - 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && last;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (last) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q <= dividend;
      r <= '0;
    end else if (busy) begin
      q <= {q[rndc_pkg::VALUE_BITS-2:0], ge};
      r <= r_next;
    end
  end

  assign quotient  = q;
  assign remainder = r[rndc_pkg::DIGIT_W-1:0];

endmodule

FILE: sv/rndc_ctrl.sv
module rndc_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  rndc_pkg::status_t  status,
  output rndc_pkg::cmd_t     cmd
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_START = 4'b0010,
    S_WAIT  = 4'b0100,
    S_EMIT  = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;

  assign in_stall = state != S_IDLE;

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_START;
        end
      end
      S_START: begin
        cmd.div_start = 1'b1;
        state_next    = S_WAIT;
      end
      S_WAIT: begin
        if (status.div_done) begin
          cmd.store = 1'b1;
          if (status.more) begin
            state_next = S_START;
          end else begin
            cmd.emit_setup = 1'b1;
            state_next     = S_EMIT;
          end
        end
      end
      S_EMIT: begin
        if (status.out_free) begin
          cmd.emit_step = 1'b1;
          if (status.emit_last) begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

FILE: sv/rndc_dp.sv
module rndc_dp (
  input  logic                             clk,
  input  logic                             rst,
  input  logic [rndc_pkg::VALUE_BITS-1:0]  value,
  input  logic                             cfg_write,
  input  logic [rndc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rndc_pkg::CFG_W-1:0]       cfg_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [rndc_pkg::CHAR_W-1:0]      digit_char,
  output logic                             is_last,
  input  rndc_pkg::cmd_t                   cmd,
  output rndc_pkg::status_t                status
);

  // Configuration registers
  logic [rndc_pkg::RADIX_W-1:0] radix;
  logic [rndc_pkg::MINL_W-1:0]  min_length;
  logic [rndc_pkg::CFG_W-1:0]   chars_low;
  logic [rndc_pkg::CFG_W-1:0]   chars_mid;
  logic [rndc_pkg::CFG_W-1:0]   chars_high;
  logic [rndc_pkg::CFG_W-1:0]   chars_top;

  // Per-number state
  logic [rndc_pkg::RADIX_W-1:0]    base;
  logic [rndc_pkg::MINL_W-1:0]     minl;
  logic [rndc_pkg::VALUE_BITS-1:0] remaining_value;
  logic [rndc_pkg::CNT_W-1:0]      digit_count;
  logic [rndc_pkg::DIGIT_W-1:0]    digit_buffer [rndc_pkg::MAX_DIGITS];
  logic [rndc_pkg::CNT_W-1:0]      pads;
  logic [rndc_pkg::CNT_W-1:0]      k;

  logic [rndc_pkg::VALUE_BITS-1:0] quotient;
  logic [rndc_pkg::DIGIT_W-1:0]    remainder;
  logic                            div_done;

  logic [rndc_pkg::RADIX_W-1:0] base_next;
  logic [rndc_pkg::MINL_W-1:0]  minl_next;
  logic [rndc_pkg::CNT_W-1:0]   count_inc;
  logic [rndc_pkg::CNT_W-1:0]   minl_ext;
  logic [rndc_pkg::CNT_W-1:0]   k_dec;
  logic [rndc_pkg::TABLE_W-1:0] char_table;
  logic [rndc_pkg::DIGIT_W-1:0] sel_digit;
  logic [rndc_pkg::CHAR_W-1:0]  sel_char;
  logic                         out_free;
  logic                         last_now;

  rndc_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (cmd.div_start),
    .dividend  (remaining_value),
    .divisor   (base),
    .quotient  (quotient),
    .remainder (remainder),
    .done      (div_done)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      radix      <= rndc_pkg::RADIX_RST;
      min_length <= rndc_pkg::MIN_LENGTH_RST;
      chars_low  <= rndc_pkg::CHARS_LOW_RST;
      chars_mid  <= rndc_pkg::CHARS_MID_RST;
      chars_high <= rndc_pkg::CHARS_HIGH_RST;
      chars_top  <= rndc_pkg::CHARS_TOP_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        rndc_pkg::REG_RADIX:      radix      <= cfg_data[rndc_pkg::RADIX_W-1:0];
        rndc_pkg::REG_MIN_LENGTH: min_length <= cfg_data[rndc_pkg::MINL_W-1:0];
        rndc_pkg::REG_CHARS_LOW:  chars_low  <= cfg_data;
        rndc_pkg::REG_CHARS_MID:  chars_mid  <= cfg_data;
        rndc_pkg::REG_CHARS_HIGH: chars_high <= cfg_data;
        rndc_pkg::REG_CHARS_TOP:  chars_top  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Clamp base into 2..32 and the minimum length to the digit limit
  always_comb begin
    priority if (radix < rndc_pkg::RADIX_MIN) begin
      base_next = rndc_pkg::RADIX_MIN;
    end else if (radix > rndc_pkg::RADIX_MAX) begin
      base_next = rndc_pkg::RADIX_MAX;
    end else begin
      base_next = radix;
    end
    if (min_length > rndc_pkg::MINL_W'(rndc_pkg::MAX_DIGITS)) begin
      minl_next = rndc_pkg::MINL_W'(rndc_pkg::MAX_DIGITS);
    end else begin
      minl_next = min_length;
    end
  end

  assign count_inc = digit_count + 1'b1;
  assign minl_ext  = rndc_pkg::CNT_W'(minl);
  assign k_dec     = k - 1'b1;

  assign char_table = {chars_top, chars_high, chars_mid, chars_low};
  assign sel_digit  = (pads != '0) ? '0 : digit_buffer[k_dec[rndc_pkg::IDX_W-1:0]];
  assign sel_char   = char_table[rndc_pkg::CHAR_W * int'(sel_digit) +: rndc_pkg::CHAR_W];
  assign last_now   = (pads == '0) && (k == rndc_pkg::CNT_W'(1));
  assign out_free   = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      remaining_value <= '0;
      digit_count     <= '0;
      pads            <= '0;
      k               <= '0;
    end else begin
      if (cmd.load) begin
        remaining_value <= value;
        digit_count     <= '0;
      end else if (cmd.store) begin
        remaining_value <= quotient;
        digit_count     <= count_inc;
      end
      if (cmd.emit_setup) begin
        pads <= (minl_ext > count_inc) ? minl_ext - count_inc : '0;
        k    <= count_inc;
      end else if (cmd.emit_step) begin
        if (pads != '0) begin
          pads <= pads - 1'b1;
        end else begin
          k <= k_dec;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      base <= base_next;
      minl <= minl_next;
    end
    if (cmd.store) begin
      digit_buffer[digit_count[rndc_pkg::IDX_W-1:0]] <= remainder;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_step) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_step) begin
      digit_char <= sel_char;
      is_last    <= last_now;
    end
  end

  assign status.div_done  = div_done;
  assign status.more      = (quotient != '0) &&
                            (count_inc < rndc_pkg::CNT_W'(rndc_pkg::MAX_DIGITS));
  assign status.out_free  = out_free;
  assign status.emit_last = last_now;

endmodule

FILE: sv/radix_number_to_digit_chars.sv
// Each digit takes a start, the steps of the bit-serial divider and a store; the first
// character is ready only after all digits of the input have been produced.
// One number at a time: the next is taken once the previous one's last character has
// entered the output register. Characters leave one per cycle while the sink does not stall.
// Reset (rst, synchronous, active high) restores the register defaults (base 10, no padding,
// table "0123456789abcdef"), empties the output register and returns the controller to idle.
module radix_number_to_digit_chars (
  input  logic                             clk,
  input  logic                             rst,
  // Input channel: one number per transfer
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [rndc_pkg::VALUE_BITS-1:0]  value,
  // Output channel: one character per transfer
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [rndc_pkg::CHAR_W-1:0]      digit_char,
  output logic                             is_last,
  // Configuration write port
  input  logic                             cfg_write,
  input  logic [rndc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rndc_pkg::CFG_W-1:0]       cfg_data
);

  // The controller sequences one number at a time:
  //   idle  -> take a number, clamp base and minimum length
  //   start -> launch one division of the remaining value by the base
  //   wait  -> on completion, store the remainder as a digit (least significant first)
  //            and either divide again or set up emission
  //   emit  -> push padding characters, then digits from the most significant down
  // The output register decouples the sink: the last character may still wait there
  // while the next number is already being taken in and divided.
  rndc_pkg::cmd_t    cmd;
  rndc_pkg::status_t status;

  rndc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  // Datapath: configuration registers, divider, digit buffer, character lookup
  // and the output register.
  rndc_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .value      (value),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .digit_char (digit_char),
    .is_last    (is_last),
    .cmd        (cmd),
    .status     (status)
  );

endmodule

FILE: bench/tb.sv
`timescale 1ns / 1ps

module tb;
  import rndc_pkg::*;

  // Run shape
  localparam int RESET_CYCLES = 12;
  localparam int N_DIRECTED   = 22;
  localparam int PHASES       = 13;
  localparam int PHASE_ITEMS  = 30;
  localparam int CHOKE_PHASE  = 5;
  localparam int CHOKE_CYCLES = 1500;
  localparam int IDLE_PAD     = 8;
  localparam int DRAIN_CYCLES = 200;
  localparam int MAX_REPORTS  = 40;
  // Slowest correct run: ~412 numbers, each 32 digits, each character waiting the longest
  // sink stall, each number after the longest gap.
  // Allow about five times that.
  localparam int CYCLE_LIMIT  = 5_000_000;

  localparam logic [TABLE_W-1:0] RESET_TABLE =
    {CHARS_TOP_RST, CHARS_HIGH_RST, CHARS_MID_RST, CHARS_LOW_RST};

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              last;
  } digit_out_t;

  typedef struct packed {
    logic [RADIX_W-1:0]    radix;
    logic [MINL_W-1:0]     min_len;
    logic [VALUE_BITS-1:0] num;
  } directed_row_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [VALUE_BITS-1:0] value = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [CHAR_W-1:0]     digit_char;
  logic                  is_last;
  logic                  cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_RADIX;
  logic [CFG_W-1:0]      cfg_data = '0;

  radix_number_to_digit_chars dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .value      (value),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .digit_char (digit_char),
    .is_last    (is_last),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // Shadow copy of the configuration, raw and as the block interprets it
  logic [RADIX_W-1:0] cur_radix   = RADIX_RST;
  logic [MINL_W-1:0]  cur_min_len = MIN_LENGTH_RST;
  logic [RADIX_W-1:0] eff_base    = RADIX_RST;
  int unsigned        eff_min_len = 0;
  logic [TABLE_W-1:0] char_table  = RESET_TABLE;

  // Characters still owed by the block, oldest first
  digit_out_t pending_chars [$];
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;
  bit          choke_pending = 1'b0;

  // Directed rows: radix, min_length, number. A blank expected string means the
  // predictor supplies the characters.
  localparam directed_row_t DIRECTED [N_DIRECTED] = '{
    '{6'd10, 6'd0,  32'd0},          // reset settings, zero gives one digit
    '{6'd10, 6'd0,  32'd1},
    '{6'd10, 6'd0,  32'd10},
    '{6'd10, 6'd0,  32'hFFFF_FFFF},
    '{6'd10, 6'd0,  32'd1000000000},
    '{6'd16, 6'd0,  32'hFFFF_FFFF},
    '{6'd16, 6'd0,  32'hDEAD_BEEF},
    '{6'd16, 6'd0,  32'd0},
    '{6'd2,  6'd0,  32'hFFFF_FFFF},  // widest digit string
    '{6'd2,  6'd0,  32'h8000_0000},
    '{6'd0,  6'd0,  32'd5},          // radix below two reads as two
    '{6'd1,  6'd0,  32'd6},
    '{6'd32, 6'd0,  32'hFFFF_FFFF},  // upper half of the table is zero
    '{6'd33, 6'd0,  32'd12345},      // radix above thirty-two reads as 32
    '{6'd63, 6'd0,  32'h7FFF_FFFF},
    '{6'd3,  6'd0,  32'hFFFF_FFFF},
    '{6'd10, 6'd5,  32'd42},
    '{6'd10, 6'd32, 32'd0},          // zero padded out to 32 characters
    '{6'd10, 6'd33, 32'd7},          // oversized minimum length clamps to 32
    '{6'd10, 6'd63, 32'd123},
    '{6'd2,  6'd32, 32'hFFFF_FFFF},  // digits exactly fill the minimum
    '{6'd8,  6'd3,  32'd8}
  };

  string directed_want [N_DIRECTED] = '{
    "0", "1", "10", "4294967295", "1000000000",
    "ffffffff", "deadbeef", "0",
    "11111111111111111111111111111111",
    "10000000000000000000000000000000",
    "101", "110", "", "", "", "",
    "00042",
    "00000000000000000000000000000000",
    "00000000000000000000000000000007",
    "",
    "11111111111111111111111111111111",
    "010"
  };

  initial begin : clock_gen
    forever #6 clk = ~clk;
  end

  // Print the first few mismatches, count them all.
  task automatic report_mismatch(input string msg);
    if (mismatch_count < MAX_REPORTS)
      $display("[%0t] mismatch: %s", $time, msg);
    mismatch_count++;
  endtask

  // Predict the characters for one number under the current settings.
  task automatic predict_digit_chars(input logic [VALUE_BITS-1:0] num);
    logic [DIGIT_W-1:0]    digs [MAX_DIGITS];
    logic [VALUE_BITS-1:0] rest;
    int unsigned           ndig;
    int unsigned           total;
    digit_out_t            d;
    rest = num;
    ndig = 0;
    do begin
      digs[ndig] = DIGIT_W'(rest % eff_base);
      rest = rest / eff_base;
      ndig++;
    end while (rest != 0 && ndig < MAX_DIGITS);
    total = (ndig < eff_min_len) ? eff_min_len : ndig;
    for (int k = 0; k < total; k++) begin
      // pad with the zero character, then the digits from the top down
      if (k < total - ndig)
        d.ch = char_table[0 +: CHAR_W];
      else
        d.ch = char_table[CHAR_W * int'(digs[total - 1 - k]) +: CHAR_W];
      d.last = (k == total - 1);
      pending_chars.push_back(d);
    end
  endtask

  // Write all six registers back to back, then mirror them in the shadow copy.
  task automatic load_settings(input logic [RADIX_W-1:0] rdx, input logic [MINL_W-1:0] minl,
                               input logic [TABLE_W-1:0] tbl);
    cfg_write <= 1'b1;
    cfg_index <= REG_RADIX;      cfg_data <= CFG_W'(rdx);                   @(posedge clk);
    cfg_index <= REG_MIN_LENGTH; cfg_data <= CFG_W'(minl);                  @(posedge clk);
    cfg_index <= REG_CHARS_LOW;  cfg_data <= tbl[0 * CFG_W +: CFG_W];       @(posedge clk);
    cfg_index <= REG_CHARS_MID;  cfg_data <= tbl[1 * CFG_W +: CFG_W];       @(posedge clk);
    cfg_index <= REG_CHARS_HIGH; cfg_data <= tbl[2 * CFG_W +: CFG_W];       @(posedge clk);
    cfg_index <= REG_CHARS_TOP;  cfg_data <= tbl[3 * CFG_W +: CFG_W];       @(posedge clk);
    cfg_write <= 1'b0;
    cur_radix   = rdx;
    cur_min_len = minl;
    char_table  = tbl;
    eff_base    = (rdx < RADIX_MIN) ? RADIX_MIN : (rdx > RADIX_MAX) ? RADIX_MAX : rdx;
    eff_min_len = (minl > MAX_DIGITS) ? MAX_DIGITS : minl;
  endtask

  // Drop valid and wait until every owed character has left, plus a short pad.
  task automatic settle_block();
    if (in_valid) in_valid <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk);
    repeat (IDLE_PAD) @(posedge clk);
  endtask

  // Offer one number, hold it until the transfer, log what it owes, then idle for any gap.
  task automatic offer_number(input logic [VALUE_BITS-1:0] num, input string want,
                              input int unsigned gap);
    digit_out_t d;
    if (!in_valid) in_valid <= 1'b1;
    value <= num;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (want.len() == 0) begin
      predict_digit_chars(num);
    end else begin
      for (int i = 0; i < want.len(); i++) begin
        d.ch   = want[i];
        d.last = (i == want.len() - 1);
        pending_chars.push_back(d);
      end
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Mostly back to back, sometimes a short gap, rarely a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r < 12) return 0;
    if (r < 18) return $urandom_range(1, 4);
    return $urandom_range(10, 40);
  endfunction

  // Sink pacing: free runs of random length, mostly short stalls, a few long ones,
  // and once a long hold-off so the block backs up into its input.
  initial begin : sink_pacing
    int unsigned run_len;
    int unsigned hold_len;
    forever begin
      run_len = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 400) : $urandom_range(1, 20);
      out_stall <= 1'b0;
      repeat (run_len) @(posedge clk);
      if (choke_pending) begin
        hold_len = CHOKE_CYCLES;
        choke_pending = 1'b0;
      end else begin
        hold_len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
      end
      out_stall <= 1'b1;
      repeat (hold_len) @(posedge clk);
    end
  end

  // Check each character transfer against the oldest owed character.
  always @(posedge clk) begin
    digit_out_t exp_d;
    if (!rst && out_valid && !out_stall) begin
      if (pending_chars.size() == 0) begin
        report_mismatch($sformatf("char 0x%02h last %0b with nothing owed", digit_char, is_last));
      end else begin
        exp_d = pending_chars.pop_front();
        if (digit_char !== exp_d.ch)
          report_mismatch($sformatf("digit_char 0x%02h, want 0x%02h", digit_char, exp_d.ch));
        if (is_last !== exp_d.last)
          report_mismatch($sformatf("is_last %0b, want %0b", is_last, exp_d.last));
      end
    end
  end

  // Hard stop if the block hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("radix_number_to_digit_chars test failed");
      $finish;
    end
  end

  initial begin : stimulus
    logic [RADIX_W-1:0]    rdx;
    logic [MINL_W-1:0]     minl;
    logic [TABLE_W-1:0]    tbl;
    logic [VALUE_BITS-1:0] num;
    logic [63:0]           pw;
    int unsigned           kind;
    int unsigned           gap;

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Directed rows; the first ones run on the reset settings untouched.
    for (int i = 0; i < N_DIRECTED; i++) begin
      if (DIRECTED[i].radix != cur_radix || DIRECTED[i].min_len != cur_min_len) begin
        settle_block();
        load_settings(DIRECTED[i].radix, DIRECTED[i].min_len, RESET_TABLE);
      end
      offer_number(DIRECTED[i].num, directed_want[i], pick_gap());
    end

    // Random phases: extremes of the settings first, then random settings.
    for (int ph = 0; ph < PHASES; ph++) begin
      for (int w = 0; w < TABLE_W / 32; w++)
        tbl[32 * w +: 32] = $urandom;
      case (ph)
        0: begin rdx = 6'd2;  minl = 6'd63; tbl = '1; end
        1: begin rdx = 6'd32; minl = 6'd0;  tbl = '0; end
        2: begin rdx = 6'd63; minl = 6'd33; end
        3: begin rdx = 6'd1;  minl = 6'd32; end
        default: begin
          if ($urandom_range(0, 9) == 0)
            rdx = $urandom_range(0, 1) ? RADIX_W'($urandom_range(0, 1))
                                       : RADIX_W'($urandom_range(33, 63));
          else
            rdx = RADIX_W'($urandom_range(2, 32));
          minl = ($urandom_range(0, 9) == 0) ? MINL_W'($urandom_range(20, 63))
                                             : MINL_W'($urandom_range(0, 12));
        end
      endcase
      settle_block();
      load_settings(rdx, minl, tbl);
      if (ph == CHOKE_PHASE) choke_pending = 1'b1;

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        kind = $urandom_range(0, 9);
        if (kind < 4) begin
          num = $urandom;
        end else if (kind < 6) begin
          num = $urandom_range(0, 1000);
        end else if (kind < 8) begin
          // land on either side of a power of the base, where the digit count steps
          pw = 64'd1;
          repeat ($urandom_range(1, 31))
            if (pw * eff_base <= 64'hFFFF_FFFF) pw = pw * eff_base;
          num = VALUE_BITS'(pw + 64'($urandom_range(0, 2)) - 64'd1);
        end else if (kind < 9) begin
          num = $urandom_range(0, 1) ? '1 : '0;
        end else begin
          num = $urandom >> $urandom_range(0, 31);
        end
        // keep offering through the hold-off so the block backs up
        gap = (ph == CHOKE_PHASE) ? 0 : pick_gap();
        offer_number(num, "", gap);
      end
    end

    settle_block();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_chars.size() == 0)
      $display("radix_number_to_digit_chars test passed");
    else
      $display("radix_number_to_digit_chars test failed");
    $finish;
  end

endmodule
